@@ hdl/nrst_pkg.sv @@
// ----------------------------------------------------------------------------
// nrst_pkg
// Types, codes and sizes shared by the note roll segment tracker modules.
// ----------------------------------------------------------------------------
package nrst_pkg;

  localparam int MAX_NOTES_DEF       = 32;
  localparam int VISIBLE_ROWS_DEF    = 64;
  localparam int VISIBLE_COLUMNS_DEF = 128;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic OP_NOTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] pitch;
    logic       note_on;
    logic [7:0] velocity;
    logic       view_active;
  } in_item_t;

  typedef struct packed {
    logic [6:0] column;
    logic [5:0] top_row;
    logic [5:0] bottom_row;
    logic       visible;
    logic       held;
    logic       empty_res;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_ON,
    CMD_OFF,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       restart;   // tick that also runs the first-use clear
    logic [6:0] pitch;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  pitch;
    logic [31:0] start;
    logic [31:0] stop;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ON_RD,
    ST_ON_CHK,
    ST_OFF_RD,
    ST_OFF_CHK,
    ST_TK_RD,
    ST_TK_CHK,
    ST_TK_FIN
  } back_state_t;

endpackage

@@ hdl/nrst_fifo.sv @@
// ----------------------------------------------------------------------------
// nrst_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module nrst_fifo
  import nrst_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= din;
    end
  end

endmodule

@@ hdl/nrst_front.sv @@
// ----------------------------------------------------------------------------
// nrst_front
// Validates note events and ticks, tracks view state, issues table commands.
// ----------------------------------------------------------------------------
module nrst_front
  import nrst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     cmd_push,
  input  logic     cmd_full,
  output cmd_t     cmd_data
);

  logic started_r, started_nxt;
  logic shown_r, shown_nxt;
  logic accept, valid_ev;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;

  always_comb begin
    valid_ev = !in_data.pitch[7] && !in_data.velocity[7]
               && (!in_data.note_on || (in_data.velocity != 8'd0));
    started_nxt       = started_r;
    shown_nxt         = shown_r;
    cmd_push          = 1'b0;
    cmd_data.kind     = CMD_TICK;
    cmd_data.restart  = 1'b0;
    cmd_data.pitch    = in_data.pitch[6:0];
    if (accept) begin
      if (in_data.op == OP_TICK) begin
        cmd_push         = 1'b1;
        cmd_data.kind    = CMD_TICK;
        cmd_data.restart = !started_r;
        started_nxt      = 1'b1;
        shown_nxt        = 1'b1;
      end else if (valid_ev) begin
        if (!in_data.view_active) begin
          // hidden after shown: clear, and the clear marks the view shown again
          if (shown_r) begin
            cmd_push      = 1'b1;
            cmd_data.kind = CMD_CLEAR;
            started_nxt   = 1'b1;
            shown_nxt     = 1'b1;
          end else begin
            shown_nxt = 1'b0;
          end
        end else begin
          shown_nxt     = 1'b1;
          cmd_push      = 1'b1;
          cmd_data.kind = in_data.note_on ? CMD_ON : CMD_OFF;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      shown_r   <= 1'b0;
    end else begin
      started_r <= started_nxt;
      shown_r   <= shown_nxt;
    end
  end

endmodule

@@ hdl/nrst_back.sv @@
// ----------------------------------------------------------------------------
// nrst_back
// Executes table commands over the segment memory and emits tick results.
// ----------------------------------------------------------------------------
module nrst_back
  import nrst_pkg::*;
#(
  parameter int MAX_NOTES       = MAX_NOTES_DEF,
  parameter int VISIBLE_ROWS    = VISIBLE_ROWS_DEF,
  parameter int VISIBLE_COLUMNS = VISIBLE_COLUMNS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  input  cmd_t      cmd_data,
  output logic      res_push,
  input  logic      res_full,
  output out_item_t res_data
);

  localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CW = $clog2(MAX_NOTES + 1);
  localparam int RW = $clog2(VISIBLE_ROWS);

  back_state_t state_r, state_nxt;
  entry_t      mem [MAX_NOTES];
  entry_t      rdata_r;
  logic [AW-1:0] raddr, waddr;
  logic        we;
  entry_t      wdata;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_r, rd_nxt, wr_r, wr_nxt, rd_m1;
  logic [31:0]   frame_r, frame_nxt;
  cmd_t          cmd_r, cmd_nxt;
  out_item_t     pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;

  // per-entry evaluation of the entry under the scan
  logic [31:0]   de, ds, end_eff;
  logic          keep, vis;
  logic [RW-1:0] top_n, bot_n;
  logic [31:0]   top_w, bot_w;
  out_item_t     cur;
  logic          match;

  assign rd_m1 = rd_r - 1'b1;

  always_comb begin
    end_eff = (rdata_r.stop != 32'd0) ? rdata_r.stop : frame_r;
    de      = frame_r - end_eff;
    ds      = frame_r - rdata_r.start;
    keep    = de[31] || (de < 32'(VISIBLE_ROWS));
    top_n   = de[31] ? '0 : de[RW-1:0];
    bot_n   = (ds < 32'(VISIBLE_ROWS - 1)) ? ds[RW-1:0] : RW'(VISIBLE_ROWS - 1);
    vis     = !ds[31] && (top_n <= bot_n)
              && (8'(rdata_r.pitch) < 8'(VISIBLE_COLUMNS));
    top_w   = 32'(top_n);
    bot_w   = 32'(bot_n);
    cur.column     = rdata_r.pitch;
    cur.top_row    = vis ? top_w[5:0] : 6'd0;
    cur.bottom_row = vis ? bot_w[5:0] : 6'd0;
    cur.visible    = vis;
    cur.held       = (rdata_r.stop == 32'd0);
    cur.empty_res  = 1'b0;
    cur.last       = 1'b0;
    match = (rdata_r.pitch == cmd_r.pitch) && (rdata_r.stop == 32'd0);
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    frame_nxt  = frame_r;
    cmd_nxt    = cmd_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_data   = pend_r;
    we         = 1'b0;
    waddr      = rd_r[AW-1:0];
    wdata      = rdata_r;
    raddr      = (state_r == ST_OFF_RD || state_r == ST_OFF_CHK) ?
                 rd_m1[AW-1:0] : rd_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_data;
          case (cmd_data.kind)
            CMD_CLEAR: begin
              count_nxt = '0;
              frame_nxt = 32'd0;
            end
            CMD_ON: begin
              rd_nxt    = '0;
              state_nxt = ST_ON_RD;
            end
            CMD_OFF: begin
              rd_nxt    = count_r;
              state_nxt = ST_OFF_RD;
            end
            CMD_TICK: begin
              frame_nxt  = (cmd_data.restart ? 32'd0 : frame_r) + 32'd1;
              if (cmd_data.restart) begin
                count_nxt = '0;
              end
              rd_nxt     = '0;
              wr_nxt     = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_TK_RD;
            end
            default: ;
          endcase
        end
      end
      ST_ON_RD: begin
        if (rd_r < count_r) begin
          state_nxt = ST_ON_CHK;
        end else begin
          // no held entry of this pitch: append if there is room
          if (count_r < CW'(MAX_NOTES)) begin
            we          = 1'b1;
            waddr       = count_r[AW-1:0];
            wdata.pitch = cmd_r.pitch;
            wdata.start = frame_r;
            wdata.stop  = 32'd0;
            count_nxt   = count_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_ON_CHK: begin
        if (match) begin
          we          = 1'b1;
          wdata.start = frame_r;
          state_nxt   = ST_IDLE;
        end else begin
          rd_nxt    = rd_r + 1'b1;
          state_nxt = ST_ON_RD;
        end
      end
      ST_OFF_RD: begin
        state_nxt = (rd_r != '0) ? ST_OFF_CHK : ST_IDLE;
      end
      ST_OFF_CHK: begin
        if (match) begin
          we         = 1'b1;
          waddr      = rd_m1[AW-1:0];
          wdata.stop = frame_r;
          state_nxt  = ST_IDLE;
        end else begin
          rd_nxt    = rd_m1;
          state_nxt = ST_OFF_RD;
        end
      end
      ST_TK_RD: begin
        state_nxt = (rd_r < count_r) ? ST_TK_CHK : ST_TK_FIN;
      end
      ST_TK_CHK: begin
        if (!keep) begin
          rd_nxt    = rd_r + 1'b1;
          state_nxt = ST_TK_RD;
        end else if (!(pend_v_r && res_full)) begin
          // release the previous survivor, hold this one until the next is known
          res_push   = pend_v_r;
          pend_nxt   = cur;
          pend_v_nxt = 1'b1;
          we         = 1'b1;
          waddr      = wr_r[AW-1:0];
          wr_nxt     = wr_r + 1'b1;
          rd_nxt     = rd_r + 1'b1;
          state_nxt  = ST_TK_RD;
        end
      end
      ST_TK_FIN: begin
        count_nxt = wr_r;
        if (pend_v_r) begin
          res_data.last = 1'b1;
        end else begin
          res_data           = '0;
          res_data.empty_res = 1'b1;
          res_data.last      = 1'b1;
        end
        if (!res_full) begin
          res_push   = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      frame_r  <= 32'd0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      frame_r  <= frame_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r   <= rd_nxt;
    wr_r   <= wr_nxt;
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ hdl/note_roll_segment_tracker.sv @@
// ----------------------------------------------------------------------------
// note_roll_segment_tracker
// Note segment table with event validation and per-frame row span reports.
// ----------------------------------------------------------------------------
//  channel   ports                         direction
//  input     in_push, in_full, in_data     events and frame ticks in
//  result    out_pop, out_empty, out_data  row spans out, oldest first
//
// Events and ticks are validated by the front and queued as commands; the back
// walks the segment memory one entry at a time: a registered read, then a check.
// Note events and ticks take longer as the number of segments grows; a tick
// also waits out any output stall. Reset is synchronous and leaves the table
// empty; no clearing pass. Both queues let either side stall independently.
// ----------------------------------------------------------------------------
module note_roll_segment_tracker
  import nrst_pkg::*;
#(
  parameter int MAX_NOTES       = MAX_NOTES_DEF,
  parameter int VISIBLE_ROWS    = VISIBLE_ROWS_DEF,
  parameter int VISIBLE_COLUMNS = VISIBLE_COLUMNS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t      cmd_in, cmd_out;
  logic      res_push, res_full;
  out_item_t res_in;

  nrst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full),
    .cmd_data (cmd_in)
  );

  nrst_fifo #(.W($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .full  (cmd_full),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_out)
  );

  nrst_back #(
    .MAX_NOTES       (MAX_NOTES),
    .VISIBLE_ROWS    (VISIBLE_ROWS),
    .VISIBLE_COLUMNS (VISIBLE_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_out),
    .res_push  (res_push),
    .res_full  (res_full),
    .res_data  (res_in)
  );

  nrst_fifo #(.W($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res_in),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (out_data)
  );

  a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full)) else $error("result pushed into full queue");

  a_cmd_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_push && cmd_full)) else $error("command pushed into full queue");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res_in.empty_res) |-> (res_in.last && !res_in.visible))
    else $error("empty-table result malformed");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

@@ sim/nrst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrst_checker
// Watches both channels of the segment tracker, keeps its own copy of the
// segment table, predicts the row spans of every frame tick and compares.
// ----------------------------------------------------------------------------
module nrst_checker
  import nrst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  logic      in_full,
  input  in_item_t  in_data,
  input  logic      out_empty,
  input  logic      out_pop,
  input  out_item_t out_data,
  output int        fail_count,
  output int        spans_pending
);

  localparam int ROWS = VISIBLE_ROWS_DEF;

  logic [6:0]  seg_pitch [MAX_NOTES_DEF];
  logic [31:0] seg_start [MAX_NOTES_DEF];
  logic [31:0] seg_end   [MAX_NOTES_DEF];
  int          seg_count;
  logic [31:0] frame_no;
  logic        started;
  logic        was_shown;
  out_item_t   span_q[$];

  assign spans_pending = span_q.size();

  function automatic logic [31:0] dist_since_end(int k);
    logic [31:0] e;
    e = (seg_end[k] != 0) ? seg_end[k] : frame_no;
    return frame_no - e;
  endfunction

  task automatic wipe_roll();
    seg_count = 0;
    frame_no  = '0;
    started   = 1'b1;
    was_shown = 1'b1;
  endtask

  task automatic apply_note(in_item_t it);
    logic prev;
    if (it.pitch > 127) return;
    if (it.note_on && (it.velocity == 0 || it.velocity > 127)) return;
    if (!it.note_on && it.velocity > 127) return;
    prev = was_shown;
    was_shown = it.view_active;
    if (!it.view_active) begin
      if (prev) wipe_roll();
      return;
    end
    if (it.note_on) begin
      for (int i = 0; i < seg_count; i++) begin
        if (seg_pitch[i] == it.pitch[6:0] && seg_end[i] == 0) begin
          seg_start[i] = frame_no;
          return;
        end
      end
      if (seg_count < MAX_NOTES_DEF) begin
        seg_pitch[seg_count] = it.pitch[6:0];
        seg_start[seg_count] = frame_no;
        seg_end[seg_count]   = '0;
        seg_count++;
      end
    end else begin
      for (int k = seg_count - 1; k >= 0; k--) begin
        if (seg_pitch[k] == it.pitch[6:0] && seg_end[k] == 0) begin
          seg_end[k] = frame_no;
          return;
        end
      end
    end
  endtask

  task automatic apply_tick();
    int          wr;
    logic [31:0] d, ds, top, bot;
    logic        vis;
    out_item_t   o;
    if (!started) wipe_roll();
    was_shown = 1'b1;
    frame_no++;
    wr = 0;
    for (int rd = 0; rd < seg_count; rd++) begin
      d = dist_since_end(rd);
      if (!d[31] && d > ROWS - 1) continue;
      seg_pitch[wr] = seg_pitch[rd];
      seg_start[wr] = seg_start[rd];
      seg_end[wr]   = seg_end[rd];
      wr++;
    end
    seg_count = wr;
    if (seg_count == 0) begin
      o = '0;
      o.empty_res = 1'b1;
      o.last = 1'b1;
      span_q.push_back(o);
      return;
    end
    for (int k = 0; k < seg_count; k++) begin
      d   = dist_since_end(k);
      ds  = frame_no - seg_start[k];
      top = d[31] ? 32'd0 : d;
      vis = 1'b0;
      bot = '0;
      if (!ds[31]) begin
        bot = (ds < ROWS - 1) ? ds : ROWS - 1;
        vis = (top <= bot) && (seg_pitch[k] < VISIBLE_COLUMNS_DEF);
      end
      o = '0;
      o.column     = seg_pitch[k];
      o.top_row    = vis ? top[5:0] : 6'd0;
      o.bottom_row = vis ? bot[5:0] : 6'd0;
      o.visible    = vis;
      o.held       = (seg_end[k] == 0);
      o.last       = (k == seg_count - 1);
      span_q.push_back(o);
    end
  endtask

  task automatic compare_span(out_item_t got);
    out_item_t want;
    if (span_q.size() == 0) begin
      $error("unexpected result transaction %p", got);
      fail_count++;
      return;
    end
    want = span_q.pop_front();
    if (got.column != want.column) begin
      $error("column: expected %0d, got %0d", want.column, got.column); fail_count++;
    end
    if (got.top_row != want.top_row) begin
      $error("top_row: expected %0d, got %0d", want.top_row, got.top_row); fail_count++;
    end
    if (got.bottom_row != want.bottom_row) begin
      $error("bottom_row: expected %0d, got %0d", want.bottom_row, got.bottom_row);
      fail_count++;
    end
    if (got.visible != want.visible) begin
      $error("visible: expected %0b, got %0b", want.visible, got.visible); fail_count++;
    end
    if (got.held != want.held) begin
      $error("held: expected %0b, got %0b", want.held, got.held); fail_count++;
    end
    if (got.empty_res != want.empty_res) begin
      $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
      fail_count++;
    end
    if (got.last != want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last); fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    seg_count  = 0;
    frame_no   = '0;
    started    = 1'b0;
    was_shown  = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      seg_count <= 0;
      frame_no  <= '0;
      started   <= 1'b0;
      was_shown <= 1'b0;
    end else begin
      if (!out_empty && out_pop) compare_span(out_data);
      if (in_push && !in_full) begin
        if (in_data.op == OP_TICK) apply_tick();
        else apply_note(in_data);
      end
    end
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives note events and frame ticks into the segment tracker: a directed
// opening, then held/released note sequences with random content and noise,
// under three idling patterns. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import nrst_pkg::*;

  localparam int WATCHDOG = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_item_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_item_t out_data;
  int        fail_count;
  int        spans_pending;
  int        send_gap_pct;
  int        recv_gap_pct;
  int        idle_cycles;
  logic [6:0] pitch_pool [4];

  note_roll_segment_tracker i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  nrst_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data      (in_data),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .spans_pending(spans_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // random pop pressure on the result side
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(99) >= recv_gap_pct);
  end

  // count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // push stays high after acceptance; the next call or the caller drops it
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_note(logic [7:0] p, logic on, logic [7:0] vel, logic view);
    in_item_t it;
    it.op = OP_NOTE;
    it.pitch = p;
    it.note_on = on;
    it.velocity = vel;
    it.view_active = view;
    send_item(it);
  endtask

  task automatic send_tick();
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'($urandom));
    it.op = OP_TICK;
    send_item(it);
  endtask

  // mostly well-formed play on a few pitches, plus noise and hidden views
  task automatic random_play(int n);
    int r;
    logic [7:0] p;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      p = {1'b0, pitch_pool[$urandom_range(3)]};
      if (r < 30) send_note(p, 1'b1, 8'($urandom_range(127, 1)), 1'b1);
      else if (r < 50) send_note(p, 1'b0, 8'($urandom_range(127)), 1'b1);
      else if (r < 80) send_tick();
      else if (r < 84) send_note(p, 1'($urandom_range(1)), 8'($urandom_range(127)), 1'b0);
      else if (r < 92) send_note({1'b0, 7'($urandom)}, 1'b1, 8'($urandom_range(127, 1)), 1'b1);
      else send_item(in_item_t'($bits(in_item_t)'($urandom)));
      if ($urandom_range(19) == 0) pitch_pool[$urandom_range(3)] = 7'($urandom);
    end
  endtask

  task automatic drain();
    while (spans_pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    idle_cycles = 0;
    send_gap_pct = 7;
    recv_gap_pct = 79;
    pitch_pool = '{7'd0, 7'd60, 7'd127, 7'd64};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first tick on empty table, extremes, invalid events, hidden view
    send_tick();
    send_note(8'd0, 1'b1, 8'd1, 1'b1);
    send_note(8'd127, 1'b1, 8'd127, 1'b1);
    send_note(8'd128, 1'b1, 8'd64, 1'b1);
    send_note(8'd255, 1'b0, 8'd0, 1'b1);
    send_note(8'd5, 1'b1, 8'd0, 1'b1);
    send_note(8'd5, 1'b1, 8'd200, 1'b1);
    send_note(8'd5, 1'b0, 8'd128, 1'b1);
    send_note(8'd0, 1'b1, 8'd90, 1'b1);
    send_tick();
    send_note(8'd127, 1'b0, 8'd0, 1'b1);
    send_note(8'd99, 1'b0, 8'd10, 1'b1);
    send_tick();
    send_tick();
    send_note(8'd40, 1'b1, 8'd50, 1'b0);
    send_note(8'd40, 1'b1, 8'd50, 1'b0);
    send_note(8'd40, 1'b1, 8'd50, 1'b1);
    send_tick();
    // fill the table past its capacity
    for (int i = 0; i < 34; i++) send_note(8'(i + 10), 1'b1, 8'd100, 1'b1);
    send_tick();
    send_note(8'd12, 1'b0, 8'd0, 1'b1);
    // scroll everything ended past the last row
    repeat (70) send_tick();

    random_play(35);
    send_gap_pct = 79;
    recv_gap_pct = 7;
    random_play(35);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_play(35);
    in_push <= 1'b0;

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && spans_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
